### sv/bges_pkg.sv
// Shared types, constants and codes for the bilinear grid elevation sampler.
// No dependencies; every other file imports this package.
package bges_pkg;

  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int GRID_SIZE = MAX_ROWS * MAX_COLS;

  // Shared divider: 56-bit dividend, 33-bit divisor, one quotient bit a cycle
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Angles in Q4.28 radians
  localparam logic signed [33:0] PI_Q      = 34'sd843314857;
  localparam logic signed [33:0] TWO_PI_Q  = 34'sd1686629714;
  localparam logic signed [33:0] HALF_PI_Q = 34'sd421657428;

  typedef enum logic [2:0] {
    CFG_SOUTH_LAT,
    CFG_WEST_LON,
    CFG_ROW_STEP,
    CFG_COL_STEP,
    CFG_ROW_COUNT,
    CFG_COL_COUNT,
    CFG_NODATA,
    CFG_WRAP
  } cfg_idx_t;

  typedef enum logic {
    KIND_WRITE,
    KIND_QUERY
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OUTSIDE,
    ST_NO_DATA,
    ST_BAD_CFG
  } stat_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         sample_row;
    logic [7:0]         sample_col;
    logic signed [15:0] sample_value;
    logic signed [31:0] query_lat;
    logic signed [31:0] query_lon;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] elevation;
    stat_t              status;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP1,
    OP_PREP2,
    OP_PREP3,
    OP_DIV_ROW,
    OP_CAPT_ROW,
    OP_DIV_COL,
    OP_CAPT_COL,
    OP_DIV_MOD,
    OP_CAPT_MOD,
    OP_INDEX,
    OP_NB_ADDR,
    OP_NB_DATA,
    OP_NB_ACC,
    OP_DIV_FIN,
    OP_EMIT_OK,
    OP_EMIT_ERR
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP1,
    S_PREP2,
    S_PREP3,
    S_CHECK,
    S_ROW_DIV,
    S_ROW_WAIT,
    S_COL_DIV,
    S_COL_WAIT,
    S_MOD_DIV,
    S_MOD_WAIT,
    S_INDEX,
    S_NB_ADDR,
    S_NB_DATA,
    S_NB_ACC,
    S_FIN_CHECK,
    S_FIN_DIV,
    S_FIN_WAIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] nb;
    stat_t      code;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_ok;
    logic lat_out;
    logic col_out;
    logic wrap;
    logic div_done;
    logic total_zero;
  } dp_stat_t;

endpackage

### sv/bges_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bges_pkg for the operand widths.
module bges_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bges_pkg::DIV_NUM_W-1:0] num,
  input  logic [bges_pkg::DIV_DEN_W-1:0] den,
  output logic [bges_pkg::DIV_NUM_W-1:0] quo,
  output logic [bges_pkg::DIV_DEN_W-1:0] rem,
  output logic                          done
);
  import bges_pkg::*;

  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r;
  logic [DIV_DEN_W:0]   shifted;
  logic                 ge;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_NUM_W-1]};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? DIV_DEN_W'(shifted - {1'b0, den_r}) : DIV_DEN_W'(shifted);
    quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
    cnt_nxt = cnt_r - DIV_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        cnt_r <= DIV_CNT_W'(DIV_NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

### sv/bges_dp.sv
// Datapath: configuration registers, grid memory, coordinate math, weights,
// accumulation and result register. Depends on bges_pkg and bges_div.
module bges_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  bges_pkg::in_item_t  in_item,
  input  bges_pkg::dp_cmd_t   cmd,
  output bges_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output bges_pkg::out_item_t out_item
);
  import bges_pkg::*;

  // configuration
  logic signed [29:0] south_lat_r;
  logic signed [30:0] west_lon_r;
  logic [29:0]        row_step_r;
  logic [29:0]        col_step_r;
  logic [8:0]         row_count_r;
  logic [8:0]         col_count_r;
  logic signed [15:0] nodata_r;
  logic               wrap_r;

  // query pipeline
  logic signed [31:0] lat_r, lon_q_r;
  logic signed [33:0] lon_n_r, west_n_r;
  logic signed [40:0] top_r;
  logic [38:0]        cspan_r;
  logic               cfg_ok_r, lat_out_r;
  logic signed [34:0] lon_a_r, lon_a_nxt;
  logic signed [39:0] ccov_r;
  logic signed [34:0] delta_r;
  logic [24:0]        rowq_r, colq_r;
  logic [DIV_NUM_W-1:0] colm_r;
  logic [ROW_W-1:0]   r0_r, r1_r;
  logic [COL_W-1:0]   c0_r, c1_r;
  logic [15:0]        rf_r, cf_r;
  logic [32:0]        w_r;
  logic signed [49:0] prod_r;
  logic               miss_r;
  logic signed [49:0] sum_r;
  logic [32:0]        total_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [15:0]        mem [GRID_SIZE];
  logic signed [15:0] mem_q;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               wr_en;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den, div_rem, span;

  logic signed [41:0] lat_diff;
  logic [34:0]        delta_mag;
  logic [49:0]        sum_mag;
  logic [38:0]        rprod;

  logic [8:0]  rlast, clast, rhi, chi, r0, c0;
  logic [9:0]  r1n, c1n;
  logic [8:0]  r1, c1;
  logic [16:0] fa, fb;

  function automatic logic signed [33:0] norm_lon(input logic signed [33:0] x);
    logic signed [33:0] t;
    t = x + PI_Q;
    if (t < 0) begin
      t = t + TWO_PI_Q;
    end else if (t >= TWO_PI_Q) begin
      t = t - TWO_PI_Q;
    end
    return t - PI_Q;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      south_lat_r <= 30'(-HALF_PI_Q);
      west_lon_r  <= 31'(-PI_Q);
      row_step_r  <= 30'd4685006;
      col_step_r  <= 30'd4685006;
      row_count_r <= 9'(MAX_ROWS);
      col_count_r <= 9'(MAX_COLS);
      nodata_r    <= -16'sd9999;
      wrap_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SOUTH_LAT: south_lat_r <= $signed(cfg_data[29:0]);
        CFG_WEST_LON:  west_lon_r  <= $signed(cfg_data[30:0]);
        CFG_ROW_STEP:  row_step_r  <= cfg_data[29:0];
        CFG_COL_STEP:  col_step_r  <= cfg_data[29:0];
        CFG_ROW_COUNT: row_count_r <= cfg_data[8:0];
        CFG_COL_COUNT: col_count_r <= cfg_data[8:0];
        CFG_NODATA:    nodata_r    <= $signed(cfg_data[15:0]);
        CFG_WRAP:      wrap_r      <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // grid memory
  assign wr_en   = (cmd.op == OP_LOAD) && (in_item.kind == KIND_WRITE);
  assign wr_addr = {in_item.sample_row[ROW_W-1:0], in_item.sample_col[COL_W-1:0]};
  assign rd_addr = {(cmd.nb[1] ? r1_r : r0_r), (cmd.nb[0] ? c1_r : c0_r)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_item.sample_value;
    end
    mem_q <= $signed(mem[rd_addr]);
  end

  // combinational helpers
  always_comb begin
    rprod    = 39'(row_count_r - 9'd1) * 39'(row_step_r);
    lat_diff = 42'(lat_r) - 42'(south_lat_r);
    delta_mag = delta_r[34] ? 35'(-delta_r) : 35'(delta_r);
    sum_mag  = sum_r[49] ? 50'(-sum_r) : 50'(sum_r);
    span     = {8'b0, col_count_r, 16'b0};

    lon_a_nxt = 35'(lon_n_r);
    if (!wrap_r) begin
      if (lon_a_nxt < 35'(west_n_r) - 35'(PI_Q)) begin
        lon_a_nxt = lon_a_nxt + 35'(TWO_PI_Q);
      end
      if (lon_a_nxt > 35'(west_n_r) + 35'(PI_Q)) begin
        lon_a_nxt = lon_a_nxt - 35'(TWO_PI_Q);
      end
    end

    rlast = row_count_r - 9'd1;
    clast = col_count_r - 9'd1;
    rhi   = rowq_r[24:16];
    chi   = colq_r[24:16];
    r0    = (rhi > rlast) ? rlast : rhi;
    c0    = (chi > clast) ? clast : chi;
    r1n   = 10'(r0) + 10'd1;
    c1n   = 10'(c0) + 10'd1;
    r1    = (r1n > 10'(rlast)) ? rlast : r1n[8:0];
    if (wrap_r) begin
      c1 = (c1n == 10'(col_count_r)) ? 9'd0 : c1n[8:0];
    end else begin
      c1 = (c1n > 10'(clast)) ? clast : c1n[8:0];
    end

    fa = cmd.nb[1] ? {1'b0, rf_r} : 17'(17'h10000 - {1'b0, rf_r});
    fb = cmd.nb[0] ? {1'b0, cf_r} : 17'(17'h10000 - {1'b0, cf_r});
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = {sum_mag[47:0], 8'b0} + DIV_NUM_W'(total_r >> 1);
    div_den   = total_r;
    case (cmd.op)
      OP_DIV_ROW: begin
        div_start = 1'b1;
        div_num   = {lat_diff[39:0], 16'b0};
        div_den   = DIV_DEN_W'(row_step_r);
      end
      OP_DIV_COL: begin
        div_start = 1'b1;
        div_num   = {5'b0, delta_mag, 16'b0};
        div_den   = DIV_DEN_W'(col_step_r);
      end
      OP_DIV_MOD: begin
        div_start = 1'b1;
        div_num   = colm_r;
        div_den   = span;
      end
      OP_DIV_FIN: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  bges_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  // query datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        lat_r   <= in_item.query_lat;
        lon_q_r <= in_item.query_lon;
      end
      OP_PREP1: begin
        lon_n_r  <= norm_lon(34'(lon_q_r));
        west_n_r <= norm_lon(34'(west_lon_r));
        top_r    <= 41'(south_lat_r) + $signed({2'b00, rprod});
        cspan_r  <= 39'(col_count_r) * 39'(col_step_r);
      end
      OP_PREP2: begin
        cfg_ok_r <= (row_step_r != '0) && (col_step_r != '0) &&
                    (row_count_r >= 9'd2) && (col_count_r >= 9'd2) &&
                    (row_count_r <= 9'(MAX_ROWS)) && (col_count_r <= 9'(MAX_COLS)) &&
                    (34'(south_lat_r) >= -HALF_PI_Q) &&
                    (top_r <= 41'(HALF_PI_Q) + 41'sd1) &&
                    !(wrap_r && (cspan_r > 39'(TWO_PI_Q) + 39'd1));
        lat_out_r <= (42'(lat_r) < 42'(south_lat_r)) || (42'(lat_r) > 42'(top_r));
        lon_a_r   <= lon_a_nxt;
        ccov_r    <= $signed({1'b0, cspan_r}) - $signed(40'(col_step_r));
      end
      OP_PREP3: begin
        delta_r <= lon_a_r - 35'(west_n_r);
      end
      OP_CAPT_ROW: begin
        rowq_r <= 25'(div_quo);
      end
      OP_CAPT_COL: begin
        // floor toward minus infinity for a westward offset
        colm_r <= (delta_r[34] && div_rem != '0) ? div_quo + DIV_NUM_W'(1) : div_quo;
        colq_r <= 25'(div_quo);
      end
      OP_CAPT_MOD: begin
        colq_r <= (delta_r[34] && div_rem != '0) ? 25'(span - div_rem) : 25'(div_rem);
      end
      OP_INDEX: begin
        r0_r    <= r0[ROW_W-1:0];
        r1_r    <= r1[ROW_W-1:0];
        c0_r    <= c0[COL_W-1:0];
        c1_r    <= c1[COL_W-1:0];
        rf_r    <= (r0 == r1) ? 16'd0 : rowq_r[15:0];
        cf_r    <= (c0 == c1) ? 16'd0 : colq_r[15:0];
        sum_r   <= '0;
        total_r <= '0;
      end
      OP_NB_ADDR: begin
        w_r <= 33'(fa * fb);
      end
      OP_NB_DATA: begin
        prod_r <= 50'($signed({1'b0, w_r}) * mem_q);
        miss_r <= (mem_q == nodata_r);
      end
      OP_NB_ACC: begin
        if (!miss_r) begin
          sum_r   <= sum_r + prod_r;
          total_r <= total_r + w_r;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT_OK) || (cmd.op == OP_EMIT_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT_OK) begin
      out_item_r.elevation <= sum_r[49] ? -$signed(div_quo[23:0]) : $signed(div_quo[23:0]);
      out_item_r.status    <= ST_OK;
    end else if (cmd.op == OP_EMIT_ERR) begin
      out_item_r.elevation <= '0;
      out_item_r.status    <= cmd.code;
    end
  end

  assign stat.cfg_ok     = cfg_ok_r;
  assign stat.lat_out    = lat_out_r;
  assign stat.col_out    = !wrap_r && (delta_r[34] || (40'(delta_r) > ccov_r));
  assign stat.wrap       = wrap_r;
  assign stat.div_done   = div_done;
  assign stat.total_zero = (total_r == '0);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### sv/bges_ctrl.sv
// Controller state machine: sequences the datapath through one request.
// Depends on bges_pkg.
module bges_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bges_pkg::kind_t    kind,
  input  bges_pkg::dp_stat_t stat,
  output logic               busy,
  output bges_pkg::dp_cmd_t  cmd
);
  import bges_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  nb_r, nb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      nb_r    <= nb_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    nb_nxt    = nb_r;
    case (state_r)
      S_IDLE:    if (start && kind == KIND_QUERY) state_nxt = S_PREP1;
      S_PREP1:   state_nxt = S_PREP2;
      S_PREP2:   state_nxt = S_PREP3;
      S_PREP3:   state_nxt = S_CHECK;
      S_CHECK: begin
        if (!stat.cfg_ok || stat.lat_out || stat.col_out) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ROW_DIV;
        end
      end
      S_ROW_DIV:  state_nxt = S_ROW_WAIT;
      S_ROW_WAIT: if (stat.div_done) state_nxt = S_COL_DIV;
      S_COL_DIV:  state_nxt = S_COL_WAIT;
      S_COL_WAIT: if (stat.div_done) state_nxt = stat.wrap ? S_MOD_DIV : S_INDEX;
      S_MOD_DIV:  state_nxt = S_MOD_WAIT;
      S_MOD_WAIT: if (stat.div_done) state_nxt = S_INDEX;
      S_INDEX: begin
        nb_nxt    = '0;
        state_nxt = S_NB_ADDR;
      end
      S_NB_ADDR:  state_nxt = S_NB_DATA;
      S_NB_DATA:  state_nxt = S_NB_ACC;
      S_NB_ACC: begin
        nb_nxt    = nb_r + 2'd1;
        state_nxt = (nb_r == 2'd3) ? S_FIN_CHECK : S_NB_ADDR;
      end
      S_FIN_CHECK: state_nxt = stat.total_zero ? S_IDLE : S_FIN_DIV;
      S_FIN_DIV:   state_nxt = S_FIN_WAIT;
      S_FIN_WAIT:  if (stat.div_done) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.nb   = nb_r;
    cmd.code = ST_OK;
    case (state_r)
      S_IDLE:     if (start) cmd.op = OP_LOAD;
      S_PREP1:    cmd.op = OP_PREP1;
      S_PREP2:    cmd.op = OP_PREP2;
      S_PREP3:    cmd.op = OP_PREP3;
      S_CHECK: begin
        if (!stat.cfg_ok) begin
          cmd.op   = OP_EMIT_ERR;
          cmd.code = ST_BAD_CFG;
        end else if (stat.lat_out || stat.col_out) begin
          cmd.op   = OP_EMIT_ERR;
          cmd.code = ST_OUTSIDE;
        end
      end
      S_ROW_DIV:  cmd.op = OP_DIV_ROW;
      S_ROW_WAIT: if (stat.div_done) cmd.op = OP_CAPT_ROW;
      S_COL_DIV:  cmd.op = OP_DIV_COL;
      S_COL_WAIT: if (stat.div_done) cmd.op = OP_CAPT_COL;
      S_MOD_DIV:  cmd.op = OP_DIV_MOD;
      S_MOD_WAIT: if (stat.div_done) cmd.op = OP_CAPT_MOD;
      S_INDEX:    cmd.op = OP_INDEX;
      S_NB_ADDR:  cmd.op = OP_NB_ADDR;
      S_NB_DATA:  cmd.op = OP_NB_DATA;
      S_NB_ACC:   cmd.op = OP_NB_ACC;
      S_FIN_CHECK: begin
        if (stat.total_zero) begin
          cmd.op   = OP_EMIT_ERR;
          cmd.code = ST_NO_DATA;
        end
      end
      S_FIN_DIV:  cmd.op = OP_DIV_FIN;
      S_FIN_WAIT: if (stat.div_done) cmd.op = OP_EMIT_OK;
      default:    cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### sv/bilinear_grid_elevation_sampler.sv
// Bilinear grid elevation sampler, top level: controller plus datapath.
// A sample write gives no result. A query runs the shared 56-step bit-serial
// divider for the row, the column, the optional wrap modulo and the final
// normalize; bad config or out-of-coverage answers are given after the
// prepare steps, before any division. One request at a time.
// Sync active-low reset restores config defaults; the grid is not cleared.
module bilinear_grid_elevation_sampler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bges_pkg::in_item_t  in_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                out_valid,
  output bges_pkg::out_item_t out_item
);
  import bges_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bges_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_item.kind),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bges_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef ASSERT_OFF
  a_result_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a query in progress");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == KIND_WRITE) |=> !out_valid)
    else $error("sample write produced a result");

  a_query_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("query finished without a result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> (out_item.elevation == '0))
    else $error("nonzero elevation with error status");
`endif

endmodule

### dv/bges_checker.sv
`timescale 1ns / 100ps
// Checker for the bilinear grid elevation sampler: mirrors grid and registers,
// predicts each query answer and compares it. Depends on bges_pkg.
module bges_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  bges_pkg::in_item_t  in_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                out_valid,
  input  bges_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_answers
);
  import bges_pkg::*;

  localparam longint PI_L     = 843314857;
  localparam longint TWO_PI_L = 2 * PI_L;
  localparam longint HALF_L   = 421657428;
  localparam longint ONE_L    = 65536;

  logic signed [15:0] grid_mem [GRID_SIZE];
  logic signed [29:0] south_r;
  logic signed [30:0] west_r;
  logic [29:0]        rstep_r, cstep_r;
  logic [8:0]         rows_r, cols_r;
  logic signed [15:0] nodata_r;
  logic               wrap_r;
  out_item_t          answer_q[$];

  assign pending_answers = answer_q.size();

  function automatic longint wrap_angle(longint x);
    longint r;
    r = (x + PI_L) % TWO_PI_L;
    if (r < 0) r += TWO_PI_L;
    return r - PI_L;
  endfunction

  function automatic out_item_t predict_elevation(in_item_t q);
    longint lat, south, west, rows, cols, rstep, cstep, nod, lon, delta;
    longint colq, rowq, span, r0, r1, rf, c0, c1, cf, sum, total, num, mag, v;
    longint w[4], rr[4], cc[4];
    out_item_t o;
    o.elevation = '0;
    south = south_r; west = wrap_angle(longint'(west_r));
    rows = rows_r; cols = cols_r; rstep = rstep_r; cstep = cstep_r; nod = nodata_r;
    lat = q.query_lat;
    if (rstep == 0 || cstep == 0 || rows < 2 || cols < 2 || rows > MAX_ROWS ||
        cols > MAX_COLS || south < -HALF_L || south + (rows - 1) * rstep > HALF_L + 1 ||
        (wrap_r && cols * cstep > TWO_PI_L + 1)) begin
      o.status = ST_BAD_CFG;
      return o;
    end
    o.status = ST_OUTSIDE;
    if (lat < south || lat > south + (rows - 1) * rstep) return o;
    lon = wrap_angle(longint'(q.query_lon));
    if (!wrap_r) begin
      if (lon < west - PI_L) lon += TWO_PI_L;
      if (lon > west + PI_L) lon -= TWO_PI_L;
    end
    delta = lon - west;
    if (wrap_r) begin
      span = cols * ONE_L;
      colq = (delta * ONE_L) / cstep;
      if ((delta * ONE_L) % cstep != 0 && delta < 0) colq -= 1;
      colq = colq % span;
      if (colq < 0) colq += span;
    end else begin
      if (delta < 0 || delta > (cols - 1) * cstep) return o;
      colq = (delta * ONE_L) / cstep;
    end
    rowq = ((lat - south) * ONE_L) / rstep;
    r0 = rowq >>> 16;
    if (r0 > rows - 1) r0 = rows - 1;
    r1 = (r0 + 1 > rows - 1) ? rows - 1 : r0 + 1;
    rf = (r0 == r1) ? 0 : rowq - (r0 <<< 16);
    c0 = colq >>> 16;
    if (c0 > cols - 1) c0 = cols - 1;
    c1 = wrap_r ? (c0 + 1) % cols : ((c0 + 1 > cols - 1) ? cols - 1 : c0 + 1);
    cf = (c0 == c1) ? 0 : colq - (c0 <<< 16);
    rr = '{r0, r0, r1, r1};
    cc = '{c0, c1, c0, c1};
    w = '{(ONE_L - rf) * (ONE_L - cf), (ONE_L - rf) * cf, rf * (ONE_L - cf), rf * cf};
    sum = 0; total = 0;
    for (int i = 0; i < 4; i++) begin
      v = grid_mem[ADDR_W'((rr[i] * MAX_COLS + cc[i]) % GRID_SIZE)];
      if (v != nod) begin
        sum += w[i] * v;
        total += w[i];
      end
    end
    if (total <= 0) begin
      o.status = ST_NO_DATA;
      return o;
    end
    num = sum * 256;
    mag = (num < 0) ? -num : num;
    mag = (mag + total / 2) / total;
    o.elevation = 24'((num < 0) ? -mag : mag);
    o.status = ST_OK;
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      south_r  = -30'sd421657428;
      west_r   = -31'sd843314857;
      rstep_r  = 30'd4685006;
      cstep_r  = 30'd4685006;
      rows_r   = 9'd256;
      cols_r   = 9'd256;
      nodata_r = -16'sd9999;
      wrap_r   = 1'b0;
      answer_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected answer elevation %0d status %0d", $time,
                   out_item.elevation, out_item.status);
        end else begin
          exp_item = answer_q.pop_front();
          if (out_item.elevation !== exp_item.elevation) begin
            fail_count++;
            $display("%0t: elevation expected %0d actual %0d", $time,
                     exp_item.elevation, out_item.elevation);
          end
          if (out_item.status !== exp_item.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_item.status, out_item.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SOUTH_LAT: south_r  = cfg_data[29:0];
          CFG_WEST_LON:  west_r   = cfg_data[30:0];
          CFG_ROW_STEP:  rstep_r  = cfg_data[29:0];
          CFG_COL_STEP:  cstep_r  = cfg_data[29:0];
          CFG_ROW_COUNT: rows_r   = cfg_data[8:0];
          CFG_COL_COUNT: cols_r   = cfg_data[8:0];
          CFG_NODATA:    nodata_r = cfg_data[15:0];
          CFG_WRAP:      wrap_r   = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_item.kind == KIND_WRITE)
          grid_mem[{in_item.sample_row, in_item.sample_col}] = in_item.sample_value;
        else
          answer_q.push_back(predict_elevation(in_item));
      end
    end
  end

endmodule

### dv/bilinear_grid_elevation_sampler_test.sv
`timescale 1ns / 100ps
// Top of the sampler testbench: loads the grid, drives register settings and
// queries, and gives the verdict. Depends on bges_pkg, bges_checker and the sampler top.
module bilinear_grid_elevation_sampler_test;
  import bges_pkg::*;

  localparam longint PI_L     = 843314857;
  localparam longint TWO_PI_L = 2 * PI_L;
  localparam longint HALF_L   = 421657428;
  localparam int     STALL_LIMIT = 5000;
  localparam int     LOAD_DIM = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count, pending_answers;
  int        stall_cycles = 0;
  bit        gaps_on = 1'b1;

  // aim values for query generation
  longint cur_south, cur_west, cur_rstep, cur_cstep, cur_rows, cur_cols, cur_nodata;

  always #5 clk = ~clk;

  bilinear_grid_elevation_sampler dut (.*);
  bges_checker u_checker (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic in_item_t make_write(int r, int c, int v);
    in_item_t it;
    it.kind = KIND_WRITE;
    it.sample_row = 8'(r);
    it.sample_col = 8'(c);
    it.sample_value = 16'(v);
    it.query_lat = $urandom;
    it.query_lon = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_query(longint lat, longint lon);
    in_item_t it;
    it.kind = KIND_QUERY;
    it.sample_row = 8'($urandom);
    it.sample_col = 8'($urandom);
    it.sample_value = 16'($urandom);
    it.query_lat = 32'(lat);
    it.query_lon = 32'(lon);
    return it;
  endfunction

  task automatic send_request(in_item_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every answer is back and the block is idle
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_answers != 0 || busy);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(longint s, longint w, longint rs, longint cs, longint nr,
                            longint nc, longint nd, longint wr);
    logic [31:0] vals[8];
    drain();
    vals = '{32'(s), 32'(w), 32'(rs), 32'(cs), 32'(nr), 32'(nc), 32'(nd), 32'(wr)};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_south = s; cur_west = w; cur_rstep = rs; cur_cstep = cs;
    cur_rows = nr; cur_cols = nc; cur_nodata = nd;
  endtask

  function automatic longint to_q32(longint x);
    if (x > 64'sd2147483647 || x < -64'sd2147483648) return longint'(signed'($urandom));
    return x;
  endfunction

  task automatic send_random_query;
    longint lat, lon, span;
    span = (cur_rows - 1) * cur_rstep;
    if (span < 0) span = 0;
    case ($urandom_range(0, 9))
      0: lat = longint'(signed'($urandom));
      1: lat = cur_south + span + $urandom_range(0, 2) - 1;
      2: lat = cur_south + $urandom_range(0, 2) - 1;
      default: lat = cur_south + (longint'($urandom) % (span + 1));
    endcase
    span = cur_cols * cur_cstep;
    if (span < 0) span = 0;
    case ($urandom_range(0, 9))
      0: lon = longint'(signed'($urandom));
      1: lon = cur_west + (longint'($urandom) % (span + 1)) + TWO_PI_L;
      2: lon = cur_west + (longint'($urandom) % (span + 1)) - TWO_PI_L;
      3: lon = cur_west + $urandom_range(0, 2) - 1;
      default: lon = cur_west + (longint'($urandom) % (span + 1));
    endcase
    send_request(make_query(to_q32(lat), to_q32(lon)));
  endtask

  // rows and columns stay inside the loaded corner of the grid
  task automatic random_phase(int count);
    longint s, rs, nr, nc, cs, w, nd, wr;
    nr = $urandom_range(2, LOAD_DIM);
    nc = $urandom_range(2, LOAD_DIM);
    s  = -HALF_L + longint'($urandom) % (HALF_L + 1);
    rs = 1 + longint'($urandom) % ((HALF_L + 1 - s) / (nr - 1));
    wr = $urandom_range(0, 1);
    cs = 1 + longint'($urandom) % (wr ? TWO_PI_L / nc : TWO_PI_L / (nc - 1));
    w  = -PI_L + longint'($urandom) % TWO_PI_L;
    case ($urandom_range(0, 3))
      0: nd = 0;
      1: nd = longint'(signed'(16'($urandom)));
      default: nd = -9999;
    endcase
    // now and then break a field outright
    if ($urandom_range(0, 7) == 0) rs = $urandom_range(0, 843314857);
    set_config(s, w, rs, cs, nr, nc, nd, wr);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 6) == 0)
        send_request(make_write($urandom_range(0, LOAD_DIM - 1),
                                $urandom_range(0, LOAD_DIM - 1),
                                $urandom_range(0, 3) == 0 ? int'(cur_nodata)
                                                          : int'($urandom)));
      else
        send_random_query();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_south = -HALF_L; cur_west = -PI_L; cur_rstep = 4685006; cur_cstep = 4685006;
    cur_rows = 256; cur_cols = 256; cur_nodata = -9999;

    // load the corner of the grid that every query reaches
    for (int r = 0; r < LOAD_DIM; r++)
      for (int c = 0; c < LOAD_DIM; c++)
        send_request(make_write(r, c, ($urandom_range(0, 7) == 0) ? -9999 :
                                (r == 0 && c == 0) ? -32768 : (r == 0 && c == 1) ? 32767
                                : int'($urandom)));

    // reset settings span past the pole: invalid
    send_request(make_query(0, 0));

    // widest rows and columns, two of each, west edge at +pi
    set_config(-HALF_L, PI_L, 843314857, 843314857, 2, 2, -9999, 0);
    send_request(make_query(-HALF_L, -PI_L));
    send_request(make_query(HALF_L + 1, 0));
    send_request(make_query(HALF_L + 2, 0));
    send_request(make_query(-HALF_L - 1, 0));
    send_request(make_query(0, 32'sh7fffffff));
    send_request(make_query(0, -64'sd2147483648));
    send_request(make_query(-64'sd2147483648, 0));

    // full wrap around the globe
    set_config(-HALF_L, -PI_L, 3306, TWO_PI_L / LOAD_DIM, LOAD_DIM, LOAD_DIM, -9999, 1);
    send_request(make_query(-HALF_L + 1000, PI_L - 1));
    send_request(make_query(-HALF_L, 32'sh7fffffff));
    send_request(make_query(-HALF_L + 3306 * (LOAD_DIM - 1), -64'sd2147483648));

    // missing neighbours and extreme samples
    set_config(-HALF_L, -PI_L, 1 << 20, 1 << 20, 3, 3, 1234, 0);
    send_request(make_write(0, 0, 1234));
    send_request(make_write(0, 1, 1234));
    send_request(make_write(1, 0, 1234));
    send_request(make_write(1, 1, 1234));
    send_request(make_query(-HALF_L + 1000, -PI_L + 1000));
    send_request(make_write(1, 1, 32767));
    send_request(make_query(-HALF_L + 1000, -PI_L + 1000));
    send_request(make_write(0, 0, -32768));
    send_request(make_query(-HALF_L + (1 << 19), -PI_L + (1 << 19)));

    // invalid settings: zero step, one row, overfull wrap
    set_config(0, 0, 0, 1000, 4, 4, -9999, 0);
    send_request(make_query(0, 0));
    set_config(0, 0, 1000, 1000, 1, 4, -9999, 0);
    send_request(make_query(0, 0));
    set_config(0, 0, 1000, 843314857, 4, 4, -9999, 1);
    send_request(make_query(0, 0));

    for (int p = 0; p < 6; p++) begin
      if (p == 5) gaps_on = 1'b0;
      random_phase(77);
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_answers != 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### bilinear_grid_elevation_sampler.f
sv/bges_pkg.sv
sv/bges_div.sv
sv/bges_dp.sv
sv/bges_ctrl.sv
sv/bilinear_grid_elevation_sampler.sv
dv/bges_checker.sv
dv/bilinear_grid_elevation_sampler_test.sv
